// ----- design/pfa_pkg.sv -----
// shared types, widths and helpers for the polygon fan-area filter and sum block
// no dependencies; used by every module of the block
package pfa_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = COORD_W + DIFF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FAN_W      = SUM_W - 1;
  localparam int VCNT_W     = 16;
  localparam int PCNT_W     = 32;
  localparam int ACC_W      = 57;
  localparam int AREA_W     = 63;
  localparam int TDATA_IN_W = 2 * COORD_W;
  localparam int TDATA_OUT_W = 64;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(AREA_W);

  localparam logic [VCNT_W-1:0]    MAX_VERTICES = 16'hFFFF;
  localparam logic [VCNT_W-1:0]    TARGET_RST   = 16'd3;
  localparam logic [ACC_W-1:0]     SAT_X2       = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [AREA_W-1:0]    Q8_MAX       = {AREA_W{1'b1}};
  localparam logic [PCNT_W-1:0]    PCNT_MAX     = {PCNT_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(AREA_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

  typedef enum logic [1:0] {
    MODE_EVEN  = 2'd0,
    MODE_ODD   = 2'd1,
    MODE_MEAN  = 2'd2,
    MODE_EXACT = 2'd3
  } pfa_mode_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_SETTLE,
    BK_LOAD,
    BK_DIV,
    BK_EMIT
  } pfa_bk_state_t;

  typedef struct packed {
    logic fan_en;
    logic poly_end;
    logic set_end;
    logic take;
  } pfa_tag_t;

  typedef struct packed {
    logic [FAN_W-1:0] fan;
    pfa_tag_t         tag;
  } pfa_entry_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SAT_X2}) ? SAT_X2 : s[ACC_W-1:0];
  endfunction

endpackage

// ----- design/pfa_front.sv -----
// front end: vertex intake, fan-triangle terms and polygon classification
// depends on pfa_pkg
module pfa_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pfa_pkg::TDATA_IN_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tuser,
  input  pfa_pkg::pfa_mode_t               mode,
  input  logic [pfa_pkg::VCNT_W-1:0]       target,
  output logic                             q_valid,
  input  logic                             q_ready,
  output pfa_pkg::pfa_entry_t              q_entry
);

  logic signed [pfa_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [pfa_pkg::VCNT_W-1:0]         vcnt_r;

  logic                               s1_valid_r, s2_valid_r, s3_valid_r;
  pfa_pkg::pfa_tag_t                  s1_tag_r, s2_tag_r, s3_tag_r;
  logic signed [pfa_pkg::COORD_W-1:0] s1_a0_r, s1_a1_r, s1_a2_r;
  logic signed [pfa_pkg::DIFF_W-1:0]  s1_b0_r, s1_b1_r, s1_b2_r;
  logic signed [pfa_pkg::PROD_W-1:0]  s2_p0_r, s2_p1_r, s2_p2_r;
  logic [pfa_pkg::FAN_W-1:0]          s3_fan_r;

  logic                               adv, acc, poly_end;
  logic signed [pfa_pkg::COORD_W-1:0] cx, cy;
  logic [pfa_pkg::VCNT_W-1:0]         vcnt_inc;
  logic                               take;
  logic signed [pfa_pkg::SUM_W-1:0]   sum;
  logic signed [pfa_pkg::SUM_W-1:0]   mag;

  // x in the low half, y in the high half
  assign cx       = in_tdata[pfa_pkg::COORD_W-1:0];
  assign cy       = in_tdata[pfa_pkg::TDATA_IN_W-1:pfa_pkg::COORD_W];
  assign poly_end = in_tlast | in_tuser;
  assign adv      = !s3_valid_r || q_ready;
  assign acc      = in_tvalid && adv;
  assign in_tready = adv;
  assign vcnt_inc = (vcnt_r == pfa_pkg::MAX_VERTICES) ? vcnt_r : vcnt_r + 1'b1;

  always_comb begin
    unique case (mode)
      pfa_pkg::MODE_EVEN:  take = !vcnt_inc[0];
      pfa_pkg::MODE_ODD:   take = vcnt_inc[0];
      pfa_pkg::MODE_MEAN:  take = 1'b1;
      pfa_pkg::MODE_EXACT: take = (vcnt_inc == target);
      default:             take = 1'b0;
    endcase
  end

  // running polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      vcnt_r    <= '0;
    end else if (acc) begin
      if (poly_end) begin
        first_x_r <= '0;
        first_y_r <= '0;
        prev_x_r  <= '0;
        prev_y_r  <= '0;
        vcnt_r    <= '0;
      end else begin
        if (vcnt_r == '0) begin
          first_x_r <= cx;
          first_y_r <= cy;
        end
        prev_x_r <= cx;
        prev_y_r <= cy;
        vcnt_r   <= vcnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign sum = pfa_pkg::SUM_W'(s2_p0_r) + pfa_pkg::SUM_W'(s2_p1_r)
             + pfa_pkg::SUM_W'(s2_p2_r);
  assign mag = sum[pfa_pkg::SUM_W-1] ? -sum : sum;

  // three-stage fan term pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r.fan_en   <= (vcnt_r >= pfa_pkg::VCNT_W'(2));
      s1_tag_r.poly_end <= poly_end;
      s1_tag_r.set_end  <= in_tuser;
      s1_tag_r.take     <= take;
      s1_a0_r <= first_x_r;
      s1_b0_r <= pfa_pkg::DIFF_W'(prev_y_r) - pfa_pkg::DIFF_W'(cy);
      s1_a1_r <= prev_x_r;
      s1_b1_r <= pfa_pkg::DIFF_W'(cy) - pfa_pkg::DIFF_W'(first_y_r);
      s1_a2_r <= cx;
      s1_b2_r <= pfa_pkg::DIFF_W'(first_y_r) - pfa_pkg::DIFF_W'(prev_y_r);

      s2_tag_r <= s1_tag_r;
      s2_p0_r  <= s1_a0_r * s1_b0_r;
      s2_p1_r  <= s1_a1_r * s1_b1_r;
      s2_p2_r  <= s1_a2_r * s1_b2_r;

      s3_tag_r <= s2_tag_r;
      s3_fan_r <= mag[pfa_pkg::FAN_W-1:0];
    end
  end

  assign q_valid     = s3_valid_r;
  assign q_entry.fan = s3_fan_r;
  assign q_entry.tag = s3_tag_r;

endmodule

// ----- design/pfa_queue.sv -----
// short queue of classified vertex terms between front and back end
// depends on pfa_pkg
module pfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  pfa_pkg::pfa_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pfa_pkg::pfa_entry_t pop_entry
);

  pfa_pkg::pfa_entry_t         mem_r [pfa_pkg::QDEPTH];
  logic [pfa_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pfa_pkg::QPTR_W:0]    cnt_r;
  logic                        do_push, do_pop;

  assign push_ready = (cnt_r != (pfa_pkg::QPTR_W+1)'(pfa_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/pfa_back.sv -----
// back end: polygon and set accumulation, mean divider and result register
// depends on pfa_pkg
module pfa_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  pfa_pkg::pfa_entry_t               q_entry,
  input  pfa_pkg::pfa_mode_t                mode,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfa_pkg::TDATA_OUT_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  pfa_pkg::pfa_bk_state_t          state_r, state_nxt;
  logic [pfa_pkg::ACC_W-1:0]       poly_acc_r, pend_r, total_r;
  logic [pfa_pkg::PCNT_W-1:0]      pcnt_r, divisor_r, rem_r;
  logic [pfa_pkg::AREA_W-1:0]      res_r, out_area_r;
  logic                            empty_r, out_empty_r, out_valid_r;
  logic [pfa_pkg::DIV_CNT_W-1:0]   dcnt_r;

  logic                            pop, ld, dstep, emit;
  logic                            is_mean, nonzero;
  logic [pfa_pkg::ACC_W-1:0]       poly_sum, poly_fin;
  logic [pfa_pkg::AREA_W-1:0]      q8;
  logic [pfa_pkg::PCNT_W:0]        trial, trial_sub;
  logic                            ge;

  assign is_mean = (mode == pfa_pkg::MODE_MEAN);
  assign nonzero = (pcnt_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfa_pkg::BK_RUN:    if (q_valid && q_entry.tag.set_end) state_nxt = pfa_pkg::BK_SETTLE;
      pfa_pkg::BK_SETTLE: state_nxt = pfa_pkg::BK_LOAD;
      pfa_pkg::BK_LOAD:   state_nxt = (is_mean && nonzero) ? pfa_pkg::BK_DIV
                                                          : pfa_pkg::BK_EMIT;
      pfa_pkg::BK_DIV:    if (dcnt_r == '0) state_nxt = pfa_pkg::BK_EMIT;
      pfa_pkg::BK_EMIT:   if (!out_valid_r || out_tready) state_nxt = pfa_pkg::BK_RUN;
      default:            state_nxt = pfa_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    q_ready = (state_r == pfa_pkg::BK_RUN);
    pop     = q_ready && q_valid;
    ld      = (state_r == pfa_pkg::BK_LOAD);
    dstep   = (state_r == pfa_pkg::BK_DIV);
    emit    = (state_r == pfa_pkg::BK_EMIT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign poly_sum = pfa_pkg::sat_add(poly_acc_r, pfa_pkg::ACC_W'(q_entry.fan));
  assign poly_fin = q_entry.tag.fan_en ? poly_sum : poly_acc_r;
  assign q8 = (total_r >= pfa_pkg::SAT_X2) ? pfa_pkg::Q8_MAX
                                           : {total_r[pfa_pkg::ACC_W-2:0], 7'b0};

  // polygon close goes through pend_r, folded into the set total in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_acc_r <= '0;
      pend_r     <= '0;
      total_r    <= '0;
      pcnt_r     <= '0;
    end else begin
      pend_r <= (pop && q_entry.tag.poly_end && q_entry.tag.take) ? poly_fin : '0;
      if (pop) begin
        if (q_entry.tag.poly_end) begin
          poly_acc_r <= '0;
        end else begin
          poly_acc_r <= poly_fin;
        end
      end
      if (ld) begin
        total_r <= '0;
        pcnt_r  <= '0;
      end else begin
        total_r <= pfa_pkg::sat_add(total_r, pend_r);
        if (pop && q_entry.tag.poly_end && (pcnt_r != pfa_pkg::PCNT_MAX)) begin
          pcnt_r <= pcnt_r + 1'b1;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle, quotient shifts into res_r
  assign trial     = {rem_r, res_r[pfa_pkg::AREA_W-1]};
  assign trial_sub = trial - {1'b0, divisor_r};
  assign ge        = (trial >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r     <= (is_mean && !nonzero) ? '0 : q8;
      empty_r   <= is_mean && !nonzero;
      rem_r     <= '0;
      divisor_r <= pcnt_r;
      dcnt_r    <= pfa_pkg::DIV_LAST;
    end else if (dstep) begin
      rem_r  <= ge ? trial_sub[pfa_pkg::PCNT_W-1:0] : trial[pfa_pkg::PCNT_W-1:0];
      res_r  <= {res_r[pfa_pkg::AREA_W-2:0], ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_area_r  <= res_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_area_r};
  assign out_tuser  = out_empty_r;

endmodule

// ----- design/polygon_fan_area_filter_sum_core.sv -----
// top level: one vertex per beat; a set_end beat gives one result, produced in mean mode
// by the 63-step restoring divider; the back end stalls while it settles, divides and
// emits that result; the 4-entry queue and then in_tready follow
// throughput one vertex per cycle otherwise, set by the 3-stage fan pipeline
// reset: synchronous active-low rst_n clears all control and accumulation state
// depends on pfa_pkg, pfa_front, pfa_queue, pfa_back
module polygon_fan_area_filter_sum_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pfa_pkg::TDATA_IN_W-1:0]    in_tdata,   // x [15:0], y [31:16]
  input  logic                              in_tlast,   // polygon_end
  input  logic                              in_tuser,   // set_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfa_pkg::TDATA_OUT_W-1:0]   out_tdata,  // area_q8 [62:0], zero [63]
  output logic                              out_tuser,  // empty_error
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pfa_pkg::pfa_mode_t          mode_r;
  logic [pfa_pkg::VCNT_W-1:0]  target_r;

  logic                        f_valid, f_ready, q_valid, q_ready;
  pfa_pkg::pfa_entry_t         f_entry, q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pfa_pkg::MODE_EVEN;
      target_r <= pfa_pkg::TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfa_pkg::CFG_MODE:   mode_r   <= pfa_pkg::pfa_mode_t'(cfg_data[1:0]);
        pfa_pkg::CFG_TARGET: target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .mode      (mode_r),
    .target    (target_r),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_entry   (f_entry)
  );

  pfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  pfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .mode       (mode_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("empty flag with nonzero area");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (mode_r == pfa_pkg::MODE_MEAN))
    else $error("empty flag outside mean mode");

  a_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[pfa_pkg::TDATA_OUT_W-1])
    else $error("area exceeds 63 bits");
`endif

endmodule

// ----- verif/pfa_area_checker.sv -----
// checker for the polygon fan-area filter and sum block: watches the vertex, result and
// register channels, keeps its own copy of the accumulation state and compares every result
// depends on pfa_pkg
`timescale 1ns / 100ps

module pfa_area_checker
  import pfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // x [15:0], y [31:16]
  input  logic                   in_tlast,   // polygon_end
  input  logic                   in_tuser,   // set_end
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [TDATA_OUT_W-1:0] out_tdata,  // area_q8 [62:0], zero [63]
  input  logic                   out_tuser,  // empty_error
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     awaiting
);

  localparam logic [63:0] AREA_CAP_X2 = 64'd1 << 56;
  localparam logic [62:0] AREA_Q8_TOP = {63{1'b1}};

  typedef struct packed {
    logic [62:0] area_q8;
    logic        empty_error;
  } set_area_t;

  pfa_mode_t          sel_mode;
  logic [15:0]        sel_target;
  logic signed [15:0] anchor_x, anchor_y, last_x, last_y;
  logic [15:0]        corner_count;
  logic [63:0]        poly_x2;
  logic [63:0]        kept_x2;
  logic [31:0]        poly_count;
  set_area_t          due_areas[$];

  function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > AREA_CAP_X2) ? AREA_CAP_X2 : s;
  endfunction

  function automatic logic [62:0] x2_to_q8(input logic [63:0] x2);
    if (x2 >= AREA_CAP_X2) return AREA_Q8_TOP;
    return 63'(x2 << 7);
  endfunction

  function automatic logic [63:0] triangle_x2(input logic signed [15:0] cx,
                                              input logic signed [15:0] cy);
    longint ax, ay, bx, by, px, py, c;
    ax = anchor_x;
    ay = anchor_y;
    bx = last_x;
    by = last_y;
    px = cx;
    py = cy;
    c  = ax * (by - py) + bx * (py - ay) + px * (ay - by);
    if (c < 0) c = -c;
    return 64'(c);
  endfunction

  task automatic accumulate_vertex(input logic [15:0] vx, input logic [15:0] vy,
                                   input logic poly_end_bit, input logic set_end_bit);
    logic      closes;
    logic      take;
    set_area_t res;
    closes = poly_end_bit | set_end_bit;
    if (corner_count == 16'd0) begin
      anchor_x = vx;
      anchor_y = vy;
    end else if (corner_count >= 16'd2) begin
      poly_x2 = capped_sum(poly_x2, triangle_x2(vx, vy));
    end
    last_x = vx;
    last_y = vy;
    if (corner_count != 16'hFFFF) corner_count = corner_count + 16'd1;
    if (closes) begin
      case (sel_mode)
        MODE_EVEN: take = ~corner_count[0];
        MODE_ODD:  take = corner_count[0];
        MODE_MEAN: take = 1'b1;
        default:   take = (corner_count == sel_target);
      endcase
      if (take) kept_x2 = capped_sum(kept_x2, poly_x2);
      if (poly_count != 32'hFFFF_FFFF) poly_count = poly_count + 32'd1;
      corner_count = '0;
      poly_x2 = '0;
      anchor_x = '0;
      anchor_y = '0;
      last_x = '0;
      last_y = '0;
    end
    if (set_end_bit) begin
      res.empty_error = 1'b0;
      if (sel_mode == MODE_MEAN) begin
        if (poly_count == 32'd0) begin
          res.area_q8 = '0;
          res.empty_error = 1'b1;
        end else begin
          res.area_q8 = 63'({1'b0, x2_to_q8(kept_x2)} / {32'd0, poly_count});
        end
      end else begin
        res.area_q8 = x2_to_q8(kept_x2);
      end
      due_areas.push_back(res);
      kept_x2 = '0;
      poly_count = '0;
    end
  endtask

  task automatic check_result_beat();
    set_area_t want;
    if (due_areas.size() == 0) begin
      mismatches++;
      $error("result beat with none due: area_q8 %0d empty_error %0b",
             out_tdata[62:0], out_tuser);
    end else begin
      want = due_areas.pop_front();
      if (out_tdata[62:0] !== want.area_q8) begin
        mismatches++;
        $error("area_q8: expected %0d, actual %0d", want.area_q8, out_tdata[62:0]);
      end
      if (out_tuser !== want.empty_error) begin
        mismatches++;
        $error("empty_error: expected %0b, actual %0b", want.empty_error, out_tuser);
      end
      if (out_tdata[63] !== 1'b0) begin
        mismatches++;
        $error("tdata pad bit: expected 0, actual %0b", out_tdata[63]);
      end
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      sel_mode     = MODE_EVEN;
      sel_target   = TARGET_RST;
      anchor_x     = '0;
      anchor_y     = '0;
      last_x       = '0;
      last_y       = '0;
      corner_count = '0;
      poly_x2      = '0;
      kept_x2      = '0;
      poly_count   = '0;
      due_areas.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) sel_mode = pfa_mode_t'(cfg_data[1:0]);
        else if (cfg_index == CFG_TARGET) sel_target = cfg_data;
      end
      if (out_tvalid && out_tready) check_result_beat();
      if (in_tvalid && in_tready)
        accumulate_vertex(in_tdata[15:0], in_tdata[31:16], in_tlast, in_tuser);
    end
    awaiting <= due_areas.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// top of the polygon fan-area testbench: clock, reset, vertex and register stimulus, verdict
// depends on pfa_pkg, polygon_fan_area_filter_sum_core and pfa_area_checker
`timescale 1ns / 100ps

module tb_top;
  import pfa_pkg::*;

  localparam int IDLE_PCT     = 22;
  localparam int RANDOM_BEATS = 950;
  localparam int SETTLE_CYC   = 100;
  localparam int STALL_LIMIT  = 4000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TDATA_IN_W-1:0]  in_tdata = '0;   // x [15:0], y [31:16]
  logic                   in_tlast = 1'b0; // polygon_end
  logic                   in_tuser = 1'b0; // set_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;       // area_q8 [62:0], zero [63]
  logic                   out_tuser;       // empty_error
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int awaiting;
  int sent_beats = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  always #6 clk = ~clk;

  polygon_fan_area_filter_sum_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pfa_area_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always @(negedge clk) out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // waits for the block to drain, then writes both registers back to back
  task automatic program_regs(input pfa_mode_t mode_code, input logic [15:0] target);
    logic [13:0] junk;
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    junk = $urandom_range(0, 1) ? 14'($urandom) : 14'd0;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {junk, mode_code};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_TARGET;
    cfg_data  <= target;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_vertex(input logic [15:0] vx, input logic [15:0] vy,
                             input logic poly_end_bit, input logic set_end_bit);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vy, vx};
    in_tlast  <= poly_end_bit;
    in_tuser  <= set_end_bit;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_beats++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      3:       v = 16'hFFFF;
      4, 5, 6: begin
        v = 16'($urandom_range(0, 400));
        v = v - 16'd200;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // random polygon; the set end sometimes travels without tlast
  task automatic push_polygon(input int corners, input bit close_set);
    logic pe;
    for (int i = 0; i < corners; i++) begin
      pe = (i == corners - 1);
      if (pe && close_set && $urandom_range(0, 4) == 0) pe = 1'b0;
      push_vertex(rand_coord(), rand_coord(), pe, close_set && (i == corners - 1));
    end
  endtask

  function automatic logic [15:0] rand_target();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(0, 2));
      2:       return 16'd3;
      default: return 16'($urandom_range(3, 10));
    endcase
  endfunction

  function automatic int rand_corners();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  initial begin
    int polys;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: even count, target 3
    push_vertex(16'h8000, 16'h8000, 1'b0, 1'b0);
    push_vertex(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    push_vertex(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    push_vertex(16'h0000, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h7FFF, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h0000, 16'h8000, 1'b1, 1'b0);
    push_vertex(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    push_vertex(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h8000, 1'b1, 1'b0);
    push_vertex(16'h0000, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    push_vertex(16'h0001, 16'h0001, 1'b0, 1'b1);

    program_regs(MODE_ODD, 16'd2);
    push_vertex(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    push_vertex(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
    push_vertex(16'h0000, 16'h8000, 1'b1, 1'b0);
    push_vertex(16'h0005, 16'hFFF0, 1'b0, 1'b0);
    push_vertex(16'hFF00, 16'h0100, 1'b0, 1'b0);
    push_vertex(16'h1234, 16'h8001, 1'b1, 1'b1);

    // target below three: only the two-vertex polygon matches
    program_regs(MODE_EXACT, 16'd2);
    push_vertex(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    push_vertex(16'h0000, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h0100, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h0000, 16'h0100, 1'b1, 1'b1);

    // mode changes between polygons of one set
    program_regs(MODE_ODD, 16'd3);
    push_vertex(16'h0000, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h7FFF, 16'h0000, 1'b0, 1'b0);
    push_vertex(16'h0000, 16'h7FFF, 1'b1, 1'b0);
    program_regs(MODE_MEAN, 16'd3);
    push_vertex(16'h8000, 16'h8000, 1'b0, 1'b0);
    push_vertex(16'h0003, 16'h8000, 1'b0, 1'b0);
    push_vertex(16'h8000, 16'h0007, 1'b1, 1'b1);

    sent_beats = 0;
    while (sent_beats < RANDOM_BEATS) begin
      calm = (sent_beats >= 400 && sent_beats < 560);
      program_regs(pfa_mode_t'($urandom_range(0, 3)), rand_target());
      polys = $urandom_range(1, 6);
      for (int p = 0; p < polys; p++) begin
        if (p > 0 && $urandom_range(0, 9) == 0)
          program_regs(pfa_mode_t'($urandom_range(0, 3)), rand_target());
        push_polygon(rand_corners(), p == polys - 1);
      end
    end

    in_tvalid <= 1'b0;

    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
